### src/mqtp_pkg.sv
// Package for the multi-queue priority task pool: sizes, codes and shared types.
// No dependencies.
package mqtp_pkg;
    localparam int NUM_QUEUES = 8;
    localparam int POOL_DEPTH = 64;
    localparam int QW = 3;
    localparam int IW = $clog2(POOL_DEPTH);
    localparam int CW = 7;
    localparam int FIFO_DEPTH = 2;

    typedef enum logic [1:0]
    {
        OP_ASSIGN  = 2'd0,
        OP_EXECUTE = 2'd1,
        OP_MERGE   = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [2:0]
    {
        ST_ASSIGNED = 3'd0,
        ST_EXECUTED = 3'd1,
        ST_MERGED   = 3'd2,
        ST_REFUSED  = 3'd3,
        ST_FULL     = 3'd4,
        ST_EMPTY    = 3'd5
    } status_t;

    typedef struct packed
    {
        logic [1:0]  op;
        logic [2:0]  queue;
        logic [2:0]  other_queue;
        logic [30:0] task_id;
        logic [31:0] priority_req;
    } cmd_t;

    typedef struct packed
    {
        logic [2:0]  status;
        logic [2:0]  result_queue;
        logic [30:0] done_id;
        logic [6:0]  queue_count;
        logic [31:0] top_priority;
        logic        last;
    } res_t;
endpackage

### src/mqtp_if.sv
// Valid/ready channel interfaces for commands and results.
// Depends on mqtp_pkg.
interface mqtp_cmd_if import mqtp_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [2:0]  queue;
    logic [2:0]  other_queue;
    logic [30:0] task_id;
    logic signed [31:0] priority_req;
    modport source (output valid, op, queue, other_queue, task_id, priority_req, input ready);
    modport sink (input valid, op, queue, other_queue, task_id, priority_req, output ready);
endinterface

interface mqtp_res_if import mqtp_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [2:0]  result_queue;
    logic [30:0] done_id;
    logic [6:0]  queue_count;
    logic signed [31:0] top_priority;
    logic        last;
    modport source (output valid, status, result_queue, done_id, queue_count,
                    top_priority, last, input ready);
    modport sink (input valid, status, result_queue, done_id, queue_count,
                  top_priority, last, output ready);
endinterface

interface mqtp_cfg_if ();
    logic       valid;
    logic       ready;
    logic [6:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

### src/multi_queue_priority_task_pool_top.sv
// Multi-queue priority task pool top level: binds channels to front and engine.
// Depends on mqtp_pkg, mqtp_if, mqtp_front and mqtp_engine.
// The engine takes one word at a time. Assign answers in the cycle after the engine
// takes the word, and the next word is taken the cycle after that result leaves.
// Execute and merge each scan the 64-entry pool through registered read ports.
// Merge scans once; execute rescans once per removed task, the last rescan seeing
// the tie run end, and holds each result until the next rescan decides its last flag.
// A result that waits for ready stalls the engine; a short command queue lets
// new words arrive while the engine scans.
module multi_queue_priority_task_pool_top import mqtp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    mqtp_cmd_if.sink  cmd,
    mqtp_res_if.source res,
    mqtp_cfg_if.sink  cfg
);
    logic       fifo_valid, fifo_pop;
    cmd_t       fifo_data;
    res_t       r;
    logic [6:0] mms_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mms_reg <= 7'd1;
        else if (cfg.valid && cfg.ready)
            mms_reg <= cfg.data;
    end

    mqtp_front u_front
    (
        .clk(clk), .rst_n(rst_n), .cmd(cmd),
        .fifo_valid(fifo_valid), .fifo_data(fifo_data), .fifo_pop(fifo_pop)
    );

    mqtp_engine u_engine
    (
        .clk(clk), .rst_n(rst_n), .merge_min_size(mms_reg),
        .cmd_valid(fifo_valid), .cmd_data(fifo_data), .cmd_pop(fifo_pop),
        .res_valid(res.valid), .res_data(r), .res_ready(res.ready)
    );

    assign res.status       = r.status;
    assign res.result_queue = r.result_queue;
    assign res.done_id      = r.done_id;
    assign res.queue_count  = r.queue_count;
    assign res.top_priority = r.top_priority;
    assign res.last         = r.last;
endmodule

### src/mqtp_front.sv
// Front end: accept command words and queue them for the engine, dropping OP_NONE words.
// Depends on mqtp_pkg and mqtp_if.
module mqtp_front import mqtp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    mqtp_cmd_if.sink    cmd,
    output logic        fifo_valid,
    output cmd_t        fifo_data,
    input  logic        fifo_pop
);
    localparam int PW = $clog2(FIFO_DEPTH);
    cmd_t            mem_reg [FIFO_DEPTH];
    logic [PW-1:0]   wp_reg, rp_reg;
    logic [PW:0]     cnt_reg;
    logic            push;

    assign cmd.ready  = (cnt_reg != (PW+1)'(FIFO_DEPTH));
    assign push       = cmd.valid && cmd.ready && (cmd.op != OP_NONE);
    assign fifo_valid = (cnt_reg != '0);
    assign fifo_data  = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= {cmd.op, cmd.queue, cmd.other_queue, cmd.task_id,
                                cmd.priority_req};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + 1'b1;
            if (fifo_pop)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (PW+1)'(push) - (PW+1)'(fifo_pop);
        end
    end

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_pop |-> fifo_valid) else $error("pop from empty queue");
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (PW+1)'(FIFO_DEPTH)) else $error("queue overflow");
    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !fifo_pop) |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("count lost push");
endmodule

### src/mqtp_engine.sv
// Back end: pool storage, per-queue counts and the scanning sequencer.
// Depends on mqtp_pkg.
module mqtp_engine import mqtp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [6:0] merge_min_size,
    input  logic       cmd_valid,
    input  cmd_t       cmd_data,
    output logic       cmd_pop,
    output logic       res_valid,
    output res_t       res_data,
    input  logic       res_ready
);
    typedef enum logic [2:0]
    {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_EXEC = 3'b100
    } state_t;

    state_t                 state_reg, state_next;
    logic [POOL_DEPTH-1:0]  valid_reg, valid_next;
    logic [QW-1:0]          owner_mem [POOL_DEPTH];
    logic signed [31:0]     prio_mem [POOL_DEPTH];
    logic [30:0]            task_mem [POOL_DEPTH];
    logic [CW-1:0]          size_reg [NUM_QUEUES];
    logic [CW-1:0]          size_next [NUM_QUEUES];
    cmd_t                   cmd_reg, cmd_next;
    logic [IW:0]            idx_reg, idx_next;
    logic                   found_reg, found_next;
    logic [IW-1:0]          best_reg, best_next;
    logic signed [31:0]     bprio_reg, bprio_next;
    logic [30:0]            bid_reg, bid_next;
    logic signed [31:0]     top_reg, top_next;
    logic                   first_reg, first_next;
    logic signed [31:0]     rd_prio_reg;
    logic [30:0]            rd_id_reg;
    logic [QW-1:0]          rd_owner_reg;
    logic                   rd_ok_reg, rd_ok_next;
    logic [IW-1:0]          rd_idx_reg;
    logic                   out_v_reg, out_v_next;
    res_t                   out_reg, out_next;
    res_t                   pend_reg, pend_next;
    logic [IW-1:0]          free_idx;
    logic                   free_ok;
    logic [QW-1:0]          q, s;
    logic                   qok, sok;
    logic [IW-1:0]          ri;
    logic                   better;
    logic                   match;
    logic                   move_wr;
    logic [CW-1:0]          dec_cnt;

    assign q   = cmd_data.queue;
    assign s   = cmd_data.other_queue;
    assign qok = 32'(q) < NUM_QUEUES;
    assign sok = 32'(s) < NUM_QUEUES;
    assign ri  = idx_reg[IW-1:0];

    always_comb
    begin
        free_ok  = 1'b0;
        free_idx = '0;
        for (int i = POOL_DEPTH - 1; i >= 0; i--)
            if (!valid_reg[i])
            begin
                free_ok  = 1'b1;
                free_idx = IW'(i);
            end
    end

    always_comb
        better = !found_reg || (rd_prio_reg > bprio_reg) ||
                 (rd_prio_reg == bprio_reg && rd_id_reg < bid_reg);

    assign match   = rd_ok_reg && (rd_owner_reg == cmd_reg.queue ||
                     (cmd_reg.op == OP_MERGE && rd_owner_reg == cmd_reg.other_queue));
    assign move_wr = (state_reg == S_SCAN) && match && (cmd_reg.op == OP_MERGE) &&
                     (rd_owner_reg != cmd_reg.queue);

    assign cmd_pop   = (state_reg == S_IDLE) && cmd_valid && !out_v_reg;
    assign res_valid = out_v_reg;
    assign res_data  = out_reg;
    assign dec_cnt   = size_reg[cmd_reg.queue] - 1'b1;

    always_ff @(posedge clk)
    begin
        rd_prio_reg  <= prio_mem[ri];
        rd_id_reg    <= task_mem[ri];
        rd_owner_reg <= owner_mem[ri];
        rd_idx_reg   <= ri;
        if (cmd_pop && cmd_data.op == OP_ASSIGN && qok && free_ok)
        begin
            prio_mem[free_idx]  <= cmd_data.priority_req;
            task_mem[free_idx]  <= cmd_data.task_id;
            owner_mem[free_idx] <= q;
        end
        else if (move_wr)
            owner_mem[rd_idx_reg] <= cmd_reg.queue;
    end

    always_comb
    begin
        state_next = state_reg;
        valid_next = valid_reg;
        for (int i = 0; i < NUM_QUEUES; i++)
            size_next[i] = size_reg[i];
        out_v_next = out_v_reg && !res_ready;
        out_next   = out_reg;
        pend_next  = pend_reg;
        cmd_next   = cmd_reg;
        idx_next   = idx_reg;
        found_next = found_reg;
        best_next  = best_reg;
        bprio_next = bprio_reg;
        bid_next   = bid_reg;
        top_next   = top_reg;
        first_next = first_reg;
        rd_ok_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_pop)
                begin
                    cmd_next   = cmd_data;
                    idx_next   = '0;
                    found_next = 1'b0;
                    first_next = 1'b1;
                    out_next   = '0;
                    out_next.result_queue = q;
                    out_next.queue_count  = qok ? size_reg[q] : '0;
                    out_next.last         = 1'b1;
                    case (cmd_data.op)
                        OP_ASSIGN:
                        begin
                            out_v_next = 1'b1;
                            if (qok && free_ok)
                            begin
                                valid_next[free_idx] = 1'b1;
                                size_next[q] = size_reg[q] + 1'b1;
                                out_next.status = ST_ASSIGNED;
                                out_next.queue_count = size_reg[q] + 1'b1;
                            end
                            else
                                out_next.status = ST_FULL;
                        end
                        OP_EXECUTE:
                        begin
                            if (!qok || size_reg[q] == '0)
                            begin
                                out_v_next = 1'b1;
                                out_next.status = ST_EMPTY;
                            end
                            else
                                state_next = S_SCAN;
                        end
                        default:
                        begin
                            if (!qok || !sok || size_reg[s] < merge_min_size)
                            begin
                                out_v_next = 1'b1;
                                out_next.status = ST_REFUSED;
                            end
                            else
                            begin
                                if (s != q)
                                begin
                                    size_next[q] = size_reg[q] + size_reg[s];
                                    size_next[s] = '0;
                                    out_next.queue_count = size_reg[q] + size_reg[s];
                                end
                                state_next = S_SCAN;
                            end
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (idx_reg <= (IW+1)'(POOL_DEPTH - 1))
                begin
                    rd_ok_next = valid_reg[ri];
                    idx_next   = idx_reg + 1'b1;
                end
                if (match && better)
                begin
                    found_next = 1'b1;
                    best_next  = rd_idx_reg;
                    bprio_next = rd_prio_reg;
                    bid_next   = rd_id_reg;
                end
                if (idx_reg == (IW+1)'(POOL_DEPTH) && !rd_ok_reg)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (cmd_reg.op == OP_MERGE)
                begin
                    out_next.status = found_reg ? ST_MERGED : ST_EMPTY;
                    out_next.top_priority = found_reg ? bprio_reg : '0;
                    out_v_next = 1'b1;
                    state_next = S_IDLE;
                end
                else if (!first_reg && out_v_reg && !res_ready)
                    state_next = S_EXEC;
                else if (found_reg && (first_reg || bprio_reg == top_reg))
                begin
                    valid_next[best_reg] = 1'b0;
                    size_next[cmd_reg.queue] = dec_cnt;
                    top_next   = bprio_reg;
                    first_next = 1'b0;
                    pend_next  = '0;
                    pend_next.status       = ST_EXECUTED;
                    pend_next.result_queue = cmd_reg.queue;
                    pend_next.done_id      = bid_reg;
                    pend_next.queue_count  = dec_cnt;
                    if (!first_reg)
                    begin
                        out_next   = pend_reg;
                        out_v_next = 1'b1;
                    end
                    idx_next   = '0;
                    found_next = 1'b0;
                    state_next = S_SCAN;
                end
                else
                begin
                    out_next      = pend_reg;
                    out_next.last = 1'b1;
                    out_v_next    = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            for (int i = 0; i < NUM_QUEUES; i++)
                size_reg[i] <= '0;
            out_v_reg <= 1'b0;
            out_reg   <= '0;
            pend_reg  <= '0;
            cmd_reg   <= '0;
            idx_reg   <= '0;
            found_reg <= 1'b0;
            best_reg  <= '0;
            bprio_reg <= '0;
            bid_reg   <= '0;
            top_reg   <= '0;
            first_reg <= 1'b0;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            for (int i = 0; i < NUM_QUEUES; i++)
                size_reg[i] <= size_next[i];
            out_v_reg <= out_v_next;
            out_reg   <= out_next;
            pend_reg  <= pend_next;
            cmd_reg   <= cmd_next;
            idx_reg   <= idx_next;
            found_reg <= found_next;
            best_reg  <= best_next;
            bprio_reg <= bprio_next;
            bid_reg   <= bid_next;
            top_reg   <= top_next;
            first_reg <= first_next;
            rd_ok_reg <= rd_ok_next;
        end
    end

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> state_reg == S_IDLE) else $error("pop while busy");
    a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && !res_ready) |=> out_v_reg && $stable(out_reg))
        else $error("result dropped");
    a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg)) else $error("state not one-hot");
endmodule
